// ===== rtl/sblcd_pkg.sv =====
// Package for the byte-budget LRU cache directory.
// Holds sizes, result codes and the item structs shared between the modules.
package sblcd_pkg;

   localparam int ENTRIES     = 16;
   localparam int KEY_BITS    = 32;
   localparam int AGE_BITS    = 16;
   localparam int SLOT_BITS   = $clog2(ENTRIES);
   localparam int CNT_BITS    = $clog2(ENTRIES + 1);
   localparam int SIZE_BITS   = 24;
   localparam int KIND_BITS   = 3;
   localparam int CSR_IDX_BITS = 1;
   localparam int QDEPTH      = 2;

   localparam logic [SIZE_BITS-1:0] LIMIT_RESET  = 24'd102400;
   localparam logic [SIZE_BITS-1:0] BUDGET_RESET = 24'd1048576;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_OBJECT_SIZE_LIMIT = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CACHE_BYTE_BUDGET = 1'd1;

   // commands
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // result kinds
   localparam logic [KIND_BITS-1:0] KIND_HIT      = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_MISS     = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_EVICTED  = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_STORED   = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_REJECTED = 3'd4;

   // classified item passed from front to back
   typedef struct packed {
      logic                 is_write;
      logic                 rejected;
      logic [31:0]          key;
      logic [SIZE_BITS-1:0] byte_size;
   } job_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [3:0]           slot;
      logic [SIZE_BITS-1:0] object_size;
      logic                 last;
   } result_type;

endpackage

// ===== rtl/sblcd_front.sv =====
// Front end: accepts items, checks writes against the size limits,
// and queues classified items for the back end. Uses sblcd_pkg.
module sblcd_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic                                 req_command,
   input  logic [31:0]                          req_key,
   input  logic [sblcd_pkg::SIZE_BITS-1:0]      req_byte_size,
   input  logic [sblcd_pkg::SIZE_BITS-1:0]      limit,
   input  logic [sblcd_pkg::SIZE_BITS-1:0]      budget,
   output logic                                 job_valid,
   output sblcd_pkg::job_type                   job,
   input  logic                                 job_take
);
   localparam int PB = $clog2(sblcd_pkg::QDEPTH);

   sblcd_pkg::job_type          q_ff [sblcd_pkg::QDEPTH];
   logic [PB-1:0]               wp_ff, wp_in, rp_ff, rp_in;
   logic [PB:0]                 cnt_ff, cnt_in;
   logic                        push_ok;
   sblcd_pkg::job_type          nj;

   assign req_full  = (cnt_ff == (PB+1)'(sblcd_pkg::QDEPTH));
   assign push_ok   = req_push && !req_full;
   assign job_valid = (cnt_ff != '0);
   assign job       = q_ff[rp_ff];

   // classify
   always_comb begin
      nj.is_write  = (req_command == sblcd_pkg::CMD_WRITE);
      nj.rejected  = (req_byte_size > limit) || (req_byte_size > budget);
      nj.key       = req_key;
      nj.byte_size = req_byte_size;
   end

   always_comb begin
      wp_in  = push_ok ? wp_ff + 1'b1 : wp_ff;
      rp_in  = job_take ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (PB+1)'(push_ok) - (PB+1)'(job_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push_ok) q_ff[wp_ff] <= nj;
   end
endmodule

// ===== rtl/sblcd_back.sv =====
// Back end: directory state, lookup, eviction and store sequencer.
// Uses sblcd_pkg; feeds a one-entry output register.
module sblcd_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [sblcd_pkg::SIZE_BITS-1:0]  budget,
   input  logic                             job_valid,
   input  sblcd_pkg::job_type               job,
   output logic                             job_take,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output sblcd_pkg::result_type            rsp
);
   localparam int E  = sblcd_pkg::ENTRIES;
   localparam int SB = sblcd_pkg::SLOT_BITS;
   localparam int SZ = sblcd_pkg::SIZE_BITS;
   localparam int AB = sblcd_pkg::AGE_BITS;
   localparam int KB = sblcd_pkg::KEY_BITS;
   localparam int CB = sblcd_pkg::CNT_BITS;
   localparam int N  = 2 * E - 1;
   localparam logic [AB-1:0] AGE_MAX = '1;

   logic [E-1:0]  valid_ff;
   logic [KB-1:0] key_ff  [E];
   logic [SZ-1:0] size_ff [E];
   logic [AB-1:0] age_ff  [E];
   logic [SZ-1:0] bytes_ff;
   logic [CB-1:0] used_ff;

   // output register
   logic                  out_valid_ff;
   sblcd_pkg::result_type out_ff;
   logic                  take_ff;
   assign rsp_empty = !out_valid_ff;
   assign rsp       = out_ff;
   assign job_take  = take_ff;
   logic out_free;
   assign out_free = !out_valid_ff || rsp_pop;

   // match vector and oldest searches, balanced comparison trees over all slots
   logic [KB-1:0] jkey;
   logic [E-1:0]  match;
   logic          hit_ok  [N];
   logic [AB-1:0] hit_age [N];
   logic [SB-1:0] hit_idx [N];
   logic          old_ok  [N];
   logic [AB-1:0] old_age [N];
   logic [SB-1:0] old_idx [N];
   logic          hit_any, old_any, free_any;
   logic [SB-1:0] hit_slot, old_slot, free_slot;
   assign jkey = job.key[KB-1:0];

   always_comb begin
      // leaves: slot i sits at node E-1+i, so lower slots are on the left
      for (int i = 0; i < E; i++) begin
         match[i]         = valid_ff[i] && (key_ff[i] == jkey);
         hit_ok[E-1+i]    = match[i];
         hit_age[E-1+i]   = age_ff[i];
         hit_idx[E-1+i]   = SB'(i);
         old_ok[E-1+i]    = valid_ff[i];
         old_age[E-1+i]   = age_ff[i];
         old_idx[E-1+i]   = SB'(i);
      end
      // right wins on a greater age or an empty left; ties go to the lower slot
      for (int n = E - 2; n >= 0; n--) begin
         if (hit_ok[2*n+2] && (!hit_ok[2*n+1] || hit_age[2*n+2] > hit_age[2*n+1])) begin
            hit_ok[n]  = 1'b1;
            hit_age[n] = hit_age[2*n+2];
            hit_idx[n] = hit_idx[2*n+2];
         end else begin
            hit_ok[n]  = hit_ok[2*n+1];
            hit_age[n] = hit_age[2*n+1];
            hit_idx[n] = hit_idx[2*n+1];
         end
         if (old_ok[2*n+2] && (!old_ok[2*n+1] || old_age[2*n+2] > old_age[2*n+1])) begin
            old_ok[n]  = 1'b1;
            old_age[n] = old_age[2*n+2];
            old_idx[n] = old_idx[2*n+2];
         end else begin
            old_ok[n]  = old_ok[2*n+1];
            old_age[n] = old_age[2*n+1];
            old_idx[n] = old_idx[2*n+1];
         end
      end
      hit_any  = hit_ok[0];
      hit_slot = hit_idx[0];
      old_any  = old_ok[0];
      old_slot = old_idx[0];
      // lowest free slot
      free_any = 1'b0; free_slot = '0;
      for (int i = E - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1; free_slot = SB'(i);
         end
      end
   end

   logic need_evict;
   logic [SZ:0] sum;
   assign sum = {1'b0, bytes_ff} + {1'b0, job.byte_size};
   assign need_evict = (sum > {1'b0, budget}) || !free_any;

   logic [SZ-1:0] bytes_dec;
   assign bytes_dec = (bytes_ff >= size_ff[old_slot]) ? bytes_ff - size_ff[old_slot] : '0;

   // step: one directory action now; done: this action ends the item
   logic step, done;
   assign step = job_valid && !take_ff && out_free;
   assign done = !job.is_write || job.rejected || !(need_evict && old_any);

   // one step per cycle while the output can take a result and take_ff is low
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         bytes_ff     <= '0;
         used_ff      <= '0;
         out_valid_ff <= 1'b0;
         take_ff      <= 1'b0;
      end else begin
         take_ff <= step && done;
         if (step) out_valid_ff <= 1'b1;
         else if (rsp_pop) out_valid_ff <= 1'b0;
         if (step) begin
            out_ff.last <= done;
            if (!job.is_write) begin
               if (hit_any) begin
                  out_ff.kind        <= sblcd_pkg::KIND_HIT;
                  out_ff.slot        <= 4'(hit_slot);
                  out_ff.object_size <= size_ff[hit_slot];
                  for (int i = 0; i < E; i++) begin
                     if (match[i]) age_ff[i] <= AB'(1);
                     else if (valid_ff[i] && age_ff[i] < AGE_MAX)
                        age_ff[i] <= age_ff[i] + 1'b1;
                  end
               end else begin
                  out_ff.kind        <= sblcd_pkg::KIND_MISS;
                  out_ff.slot        <= '0;
                  out_ff.object_size <= '0;
               end
            end else if (job.rejected) begin
               out_ff.kind        <= sblcd_pkg::KIND_REJECTED;
               out_ff.slot        <= '0;
               out_ff.object_size <= '0;
            end else if (need_evict && old_any) begin
               out_ff.kind          <= sblcd_pkg::KIND_EVICTED;
               out_ff.slot          <= 4'(old_slot);
               out_ff.object_size   <= size_ff[old_slot];
               valid_ff[old_slot]   <= 1'b0;
               bytes_ff             <= bytes_dec;
               if (used_ff != '0) used_ff <= used_ff - 1'b1;
            end else begin
               // store; an empty table clears the counters first
               out_ff.kind        <= sblcd_pkg::KIND_STORED;
               out_ff.slot        <= 4'(free_slot);
               out_ff.object_size <= job.byte_size;
               for (int i = 0; i < E; i++) begin
                  if (valid_ff[i] && SB'(i) != free_slot && age_ff[i] < AGE_MAX)
                     age_ff[i] <= age_ff[i] + 1'b1;
               end
               valid_ff[free_slot] <= 1'b1;
               key_ff[free_slot]   <= jkey;
               size_ff[free_slot]  <= job.byte_size;
               age_ff[free_slot]   <= AB'(1);
               if (need_evict) begin
                  bytes_ff <= job.byte_size;
                  used_ff  <= CB'(1);
               end else begin
                  bytes_ff <= bytes_ff + job.byte_size;
                  used_ff  <= used_ff + 1'b1;
               end
            end
         end
      end
   end
endmodule

// ===== rtl/size_budget_lru_cache_directory_top.sv =====
// Top level of the byte-budget LRU cache directory.
// Instantiates sblcd_front and sblcd_back; uses sblcd_pkg.
//
// A read gives one result. A write gives one rejected result, or one result
// per evicted entry and then a stored result; the back end makes one
// directory step per result, fed from the two-entry input queue.
// Configuration writes must be made while the block is idle.
module size_budget_lru_cache_directory_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_command,
   input  logic [31:0] req_key,
   input  logic [23:0] req_byte_size,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_kind,
   output logic [3:0]  rsp_slot,
   output logic [23:0] rsp_object_size,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [23:0] csr_write_data
);
   logic [23:0] limit_ff, budget_ff;
   logic                  job_valid, job_take;
   sblcd_pkg::job_type    job;
   sblcd_pkg::result_type rsp;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= sblcd_pkg::LIMIT_RESET;
         budget_ff <= sblcd_pkg::BUDGET_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            sblcd_pkg::CSR_OBJECT_SIZE_LIMIT: limit_ff  <= csr_write_data;
            sblcd_pkg::CSR_CACHE_BYTE_BUDGET: budget_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   sblcd_front u_front (
      .clock, .reset,
      .req_push(push), .req_full(full),
      .req_command, .req_key, .req_byte_size,
      .limit(limit_ff), .budget(budget_ff),
      .job_valid, .job, .job_take
   );

   sblcd_back u_back (
      .clock, .reset,
      .budget(budget_ff),
      .job_valid, .job, .job_take,
      .rsp_empty(empty), .rsp_pop(pop), .rsp
   );

   assign rsp_kind        = rsp.kind;
   assign rsp_slot        = rsp.slot;
   assign rsp_object_size = rsp.object_size;
   assign rsp_last        = rsp.last;
endmodule

// ===== verif/tb_size_budget_lru_cache_directory_top.sv =====
// Testbench for the byte-budget LRU cache directory top level.
// Predicts every result item in SystemVerilog, checks them in order; uses sblcd_pkg.
module tb_size_budget_lru_cache_directory_top;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [sblcd_pkg::AGE_BITS-1:0] AGE_MAX = '1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_command = 1'b0;
   logic [31:0] req_key = '0;
   logic [23:0] req_byte_size = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [2:0]  rsp_kind;
   logic [3:0]  rsp_slot;
   logic [23:0] rsp_object_size;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [23:0] csr_write_data = '0;

   size_budget_lru_cache_directory_top u_top (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // directory shadow
   logic                            dir_valid [sblcd_pkg::ENTRIES];
   logic [31:0]                     dir_key   [sblcd_pkg::ENTRIES];
   logic [sblcd_pkg::SIZE_BITS-1:0] dir_size  [sblcd_pkg::ENTRIES];
   logic [sblcd_pkg::AGE_BITS-1:0]  dir_age   [sblcd_pkg::ENTRIES];
   logic [sblcd_pkg::SIZE_BITS-1:0] bytes_used;
   int                              slots_used;
   logic [sblcd_pkg::SIZE_BITS-1:0] size_limit;
   logic [sblcd_pkg::SIZE_BITS-1:0] byte_budget;

   sblcd_pkg::result_type pending_results [$];
   int  errors = 0;
   int  idle_cycles = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  recv_hold = 1'b0;
   logic [31:0] recent_keys [$];

   function automatic sblcd_pkg::result_type mk(logic [2:0] k, int s, logic [23:0] sz,
                                                logic l);
      sblcd_pkg::result_type r;
      r.kind = k; r.slot = s[3:0]; r.object_size = sz; r.last = l;
      return r;
   endfunction

   // compute expected result items for one accepted item
   task automatic predict_directory(logic cmd, logic [31:0] key, logic [23:0] sz);
      int hit, oldest, free_slot;
      hit = -1;
      if (cmd == sblcd_pkg::CMD_READ) begin
         for (int i = 0; i < sblcd_pkg::ENTRIES; i++)
            if (dir_valid[i] && dir_key[i] == key && (hit < 0 || dir_age[i] > dir_age[hit]))
               hit = i;
         if (hit < 0) begin
            pending_results.push_back(mk(sblcd_pkg::KIND_MISS, 0, '0, 1'b1));
         end else begin
            pending_results.push_back(mk(sblcd_pkg::KIND_HIT, hit, dir_size[hit], 1'b1));
            for (int i = 0; i < sblcd_pkg::ENTRIES; i++) begin
               if (!dir_valid[i]) continue;
               if (dir_key[i] == key) dir_age[i] = sblcd_pkg::AGE_BITS'(1);
               else if (dir_age[i] != AGE_MAX) dir_age[i]++;
            end
         end
         return;
      end
      if (sz > size_limit || sz > byte_budget) begin
         pending_results.push_back(mk(sblcd_pkg::KIND_REJECTED, 0, '0, 1'b1));
         return;
      end
      while (25'(bytes_used) + 25'(sz) > 25'(byte_budget) ||
             slots_used >= sblcd_pkg::ENTRIES) begin
         oldest = -1;
         for (int i = 0; i < sblcd_pkg::ENTRIES; i++)
            if (dir_valid[i] && (oldest < 0 || dir_age[i] > dir_age[oldest])) oldest = i;
         if (oldest < 0) begin
            bytes_used = '0; slots_used = 0;
            break;
         end
         pending_results.push_back(mk(sblcd_pkg::KIND_EVICTED, oldest, dir_size[oldest],
                                      1'b0));
         dir_valid[oldest] = 1'b0;
         bytes_used = (bytes_used >= dir_size[oldest]) ? bytes_used - dir_size[oldest] : '0;
         if (slots_used > 0) slots_used--;
      end
      free_slot = 0;
      for (int i = sblcd_pkg::ENTRIES - 1; i >= 0; i--)
         if (!dir_valid[i]) free_slot = i;
      dir_valid[free_slot] = 1'b1;
      dir_key[free_slot] = key;
      dir_size[free_slot] = sz;
      dir_age[free_slot] = sblcd_pkg::AGE_BITS'(1);
      for (int i = 0; i < sblcd_pkg::ENTRIES; i++)
         if (dir_valid[i] && i != free_slot && dir_age[i] != AGE_MAX) dir_age[i]++;
      bytes_used = bytes_used + sz;
      slots_used++;
      pending_results.push_back(mk(sblcd_pkg::KIND_STORED, free_slot, sz, 1'b1));
   endtask

   // offer one item, hold it until accepted; push stays high for a following item
   task automatic send_item(logic cmd, logic [31:0] key, logic [23:0] sz);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_command <= cmd;
      req_key <= key;
      req_byte_size <= sz;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_directory(cmd, key, sz);
      if (cmd == sblcd_pkg::CMD_WRITE) begin
         recent_keys.push_back(key);
         if (recent_keys.size() > 24) void'(recent_keys.pop_front());
      end
   endtask

   // stop sending, wait for all results, then let the block settle before touching registers
   task automatic drain_results();
      push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_register(logic [0:0] idx, logic [23:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      if (idx == sblcd_pkg::CSR_OBJECT_SIZE_LIMIT) size_limit = val;
      else byte_budget = val;
   endtask

   // receiver: random pop, optional long hold-off
   always @(posedge clock) begin
      if (reset) pop <= 1'b0;
      else pop <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      sblcd_pkg::result_type want;
      if (!reset && pop && !empty) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result kind %0d slot %0d size %0d last %0d", $time,
                     rsp_kind, rsp_slot, rsp_object_size, rsp_last);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_kind !== want.kind) begin
               $display("%0t: kind expected %0d actual %0d", $time, want.kind, rsp_kind);
               errors++;
            end
            if (rsp_slot !== want.slot) begin
               $display("%0t: slot expected %0d actual %0d", $time, want.slot, rsp_slot);
               errors++;
            end
            if (rsp_object_size !== want.object_size) begin
               $display("%0t: object_size expected %0d actual %0d", $time,
                        want.object_size, rsp_object_size);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %0d actual %0d", $time, want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] pick_key();
      if (recent_keys.size() != 0 && $urandom_range(99) < 60)
         return recent_keys[$urandom_range(recent_keys.size() - 1)];
      return 32'($urandom_range(7));
   endfunction

   // field extremes, read miss, rejection, duplicates, full table
   task automatic test_directed();
      send_item(sblcd_pkg::CMD_READ, 32'hFFFF_FFFF, 24'hFFFFFF);
      send_item(sblcd_pkg::CMD_WRITE, 32'h0, 24'hFFFFFF);
      send_item(sblcd_pkg::CMD_WRITE, 32'hFFFF_FFFF, 24'd0);
      send_item(sblcd_pkg::CMD_WRITE, 32'hFFFF_FFFF, 24'd102400);
      send_item(sblcd_pkg::CMD_WRITE, 32'h0, 24'd102401);
      send_item(sblcd_pkg::CMD_READ, 32'hFFFF_FFFF, 24'd0);
      send_item(sblcd_pkg::CMD_READ, 32'h0, 24'd0);
      for (int i = 0; i < 17; i++) send_item(sblcd_pkg::CMD_WRITE, 32'(i), 24'(i * 1000));
      send_item(sblcd_pkg::CMD_READ, 32'd5, 24'd0);
   endtask

   // lowered budget and zero limit
   task automatic test_budget_edges();
      drain_results();
      write_register(sblcd_pkg::CSR_CACHE_BYTE_BUDGET, 24'd3000);
      send_item(sblcd_pkg::CMD_WRITE, 32'd99, 24'd10);
      send_item(sblcd_pkg::CMD_WRITE, 32'd98, 24'd3000);
      drain_results();
      write_register(sblcd_pkg::CSR_OBJECT_SIZE_LIMIT, 24'd0);
      send_item(sblcd_pkg::CMD_WRITE, 32'd1, 24'd0);
      send_item(sblcd_pkg::CMD_WRITE, 32'd1, 24'd1);
      drain_results();
      write_register(sblcd_pkg::CSR_OBJECT_SIZE_LIMIT, 24'hFFFFFF);
      write_register(sblcd_pkg::CSR_CACHE_BYTE_BUDGET, 24'd1);
      send_item(sblcd_pkg::CMD_WRITE, 32'd2, 24'd1);
      send_item(sblcd_pkg::CMD_WRITE, 32'd3, 24'd2);
   endtask

   // random traffic under one register setting
   task automatic test_random(int n, logic [23:0] lim, logic [23:0] bud, logic [23:0] max_sz);
      logic [23:0] sz;
      drain_results();
      write_register(sblcd_pkg::CSR_OBJECT_SIZE_LIMIT, lim);
      write_register(sblcd_pkg::CSR_CACHE_BYTE_BUDGET, bud);
      for (int i = 0; i < n; i++) begin
         sz = ($urandom_range(19) == 0) ? 24'($urandom) : 24'($urandom_range(max_sz));
         if ($urandom_range(29) == 0)
            send_item(1'($urandom_range(1)), $urandom, sz);
         else
            send_item(1'($urandom_range(1)), pick_key(), sz);
      end
   endtask

   // receiver stalls long while the sender keeps pushing
   task automatic test_backpressure();
      drain_results();
      fork
         begin
            recv_hold = 1'b1;
            repeat (300) @(posedge clock);
            recv_hold = 1'b0;
         end
         for (int i = 0; i < 30; i++)
            send_item(1'($urandom_range(1)), pick_key(), 24'($urandom_range(500)));
      join
      drain_results();
   endtask

   initial begin
      for (int i = 0; i < sblcd_pkg::ENTRIES; i++) begin
         dir_valid[i] = 1'b0; dir_key[i] = '0; dir_size[i] = '0; dir_age[i] = '0;
      end
      bytes_used = '0; slots_used = 0;
      size_limit = sblcd_pkg::LIMIT_RESET; byte_budget = sblcd_pkg::BUDGET_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 8; recv_idle_pct = 58;
      test_directed();
      test_budget_edges();
      test_random(150, 24'd2000, 24'd6000, 24'd2100);
      send_idle_pct = 58; recv_idle_pct = 8;
      test_random(150, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      test_backpressure();
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(100, 24'd300, 24'd1200, 24'd320);
      test_random(10, 24'd102400, 24'd1048576, 24'd200000);

      drain_results();
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/sblcd_pkg.sv
rtl/sblcd_front.sv
rtl/sblcd_back.sv
rtl/size_budget_lru_cache_directory_top.sv
verif/tb_size_budget_lru_cache_directory_top.sv
